// ----- rtl/qte_pkg.sv -----
// Shared constants, widths and helper functions for the quaternion to Euler block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package qte_pkg;

	// Payload widths.
	localparam int QW        = 16;  // quaternion component, Q1.14
	localparam int PROD_W    = 32;  // product of two components
	localparam int SUM_W     = 34;  // doubled sum of two products, Q.28
	localparam int PA_W      = 30;  // clamped arcsine argument, +-2^28
	localparam int SQ_W      = 2 * PA_W;
	localparam int REM_W     = 58;  // radicand and remainder of the square root
	localparam int ROOT_BITS = 29;  // floor root of at most 2^56
	localparam int CW        = 37;  // CORDIC vector width
	localparam int ZW        = 24;  // CORDIC angle, Q.20 radians
	localparam int RW        = 16;  // rounded angle before saturation

	localparam int ROLL_W  = 15;
	localparam int PITCH_W = 14;

	// Pipeline depths.
	localparam int CORDIC_STEPS = 20;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
	localparam int SQRT_LAT     = ROOT_BITS;
	localparam int FRONT_LAT    = 3;
	localparam int TOTAL_LAT    = FRONT_LAT + SQRT_LAT + CORDIC_LAT + 1;

	localparam logic signed [SUM_W-1:0] ONE_Q28      = SUM_W'(64'sd268435456);
	localparam logic signed [ZW-1:0]    PI_Q20       = ZW'(3294199);
	localparam logic signed [ZW-1:0]    ROUND_HALF   = ZW'(128);
	localparam logic signed [RW-1:0]    LIM_PI       = RW'(12868);
	localparam logic signed [RW-1:0]    LIM_HALF_PI  = RW'(6434);

	// Arctangent of 2^-i in Q.20 radians, rounded.
	function automatic logic signed [ZW-1:0] atan_lut(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = ZW'(823550);
			1: v = ZW'(486170);
			2: v = ZW'(256879);
			3: v = ZW'(130396);
			4: v = ZW'(65451);
			5: v = ZW'(32757);
			6: v = ZW'(16383);
			7: v = ZW'(8192);
			8: v = ZW'(4096);
			9: v = ZW'(2048);
			10: v = ZW'(1024);
			11: v = ZW'(512);
			12: v = ZW'(256);
			13: v = ZW'(128);
			14: v = ZW'(64);
			15: v = ZW'(32);
			16: v = ZW'(16);
			17: v = ZW'(8);
			18: v = ZW'(4);
			19: v = ZW'(2);
			default: v = '0;
		endcase
		return v;
	endfunction

	// Round a Q.20 angle to Q3.12 (half up) and saturate to +-lim.
	function automatic logic signed [RW-1:0] round_sat(input logic signed [ZW-1:0] a,
			input logic signed [RW-1:0] lim);
		logic signed [ZW-1:0] t;
		logic signed [RW-1:0] r;
		t = (a + ROUND_HALF) >>> 8;
		r = RW'(t);
		if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		return r;
	endfunction

endpackage

// ----- rtl/qte_if.sv -----
// Valid/ready channel interfaces for quaternion input and Euler angle output.
// Depends on qte_pkg for field widths.
`timescale 1ns / 1ps

interface qte_quat_if import qte_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [QW-1:0] quat_w;
	logic signed [QW-1:0] quat_x;
	logic signed [QW-1:0] quat_y;
	logic signed [QW-1:0] quat_z;

	modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if import qte_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [ROLL_W-1:0]  roll_angle;
	logic signed [PITCH_W-1:0] pitch_angle;
	logic signed [ROLL_W-1:0]  yaw_angle;
	logic                      pitch_clamped;

	modport source(output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
		input ready);
	modport sink(input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
		output ready);
endinterface

// ----- rtl/qte_isqrt.sv -----
// Pipelined floor square root, one result bit per register stage.
// Depends on qte_pkg for widths.
`timescale 1ns / 1ps

module qte_isqrt import qte_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [REM_W-1:0]     radicand,
	output logic [ROOT_BITS-1:0] root
);

	logic [REM_W-1:0]     rem_s  [0:ROOT_BITS];
	logic [ROOT_BITS-1:0] root_s [0:ROOT_BITS];

	assign rem_s[0]  = radicand;
	assign root_s[0] = '0;

	// Each stage tries the next lower root bit against the running remainder.
	for (genvar j = 0; j < ROOT_BITS; j++) begin : g_step
		localparam int B = ROOT_BITS - 1 - j;
		logic [REM_W-1:0] trial;
		assign trial = (REM_W'(root_s[j]) << (B + 1)) | (REM_W'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[j] >= trial) begin
					rem_s[j+1]  <= rem_s[j] - trial;
					root_s[j+1] <= root_s[j] | (ROOT_BITS'(1) << B);
				end else begin
					rem_s[j+1]  <= rem_s[j];
					root_s[j+1] <= root_s[j];
				end
			end
		end
	end

	assign root = root_s[ROOT_BITS];

endmodule

// ----- rtl/qte_cordic.sv -----
// Pipelined vectoring CORDIC giving the four-quadrant arctangent in Q.20 radians.
// Depends on qte_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module qte_cordic import qte_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] num,
	input  logic signed [CW-1:0] den,
	output logic signed [ZW-1:0] angle
);

	logic signed [CW-1:0] n_s    [0:CORDIC_STEPS];
	logic signed [CW-1:0] d_s    [0:CORDIC_STEPS];
	logic signed [ZW-1:0] z_s    [0:CORDIC_STEPS];
	logic                 zero_s [0:CORDIC_STEPS];

	// Fold the left half plane onto the right and start the angle at +-pi.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (num == '0) && (den == '0);
			if (den < 0) begin
				n_s[0] <= -num;
				d_s[0] <= -den;
				z_s[0] <= (num >= 0) ? PI_Q20 : -PI_Q20;
			end else begin
				n_s[0] <= num;
				d_s[0] <= den;
				z_s[0] <= '0;
			end
		end
	end

	// One micro-rotation per stage, driving the numerator toward zero.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (n_s[i] >= 0) begin
					d_s[i+1] <= d_s[i] + (n_s[i] >>> i);
					n_s[i+1] <= n_s[i] - (d_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_lut(i);
				end else begin
					d_s[i+1] <= d_s[i] - (n_s[i] >>> i);
					n_s[i+1] <= n_s[i] + (d_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_lut(i);
				end
			end
		end
	end

	assign angle = zero_s[CORDIC_STEPS] ? '0 : z_s[CORDIC_STEPS];

endmodule

// ----- rtl/quaternion_to_euler_angles.sv -----
// Quaternion to ZYX Euler angles: accepts one Q1.14 quaternion per cycle and returns
// roll, pitch and yaw in radians with 12 fraction bits (Q2.12 roll and yaw, Q1.12 pitch).
// The pipeline length is set mostly by the 29-stage square root feeding the pitch arctangent followed
// by the 21-stage CORDIC; roll and yaw ride alongside so all three leave together. The
// whole pipeline advances together and holds while a finished result is not taken.
// Depends on qte_pkg, qte_if, qte_isqrt and qte_cordic.
`timescale 1ns / 1ps

module quaternion_to_euler_angles import qte_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	qte_quat_if.sink  quat_in,
	qte_euler_if.source euler_out
);

	logic en;
	logic [TOTAL_LAT-1:0] vld_q;

	// The pipeline moves when the output register is empty or being drained.
	assign en            = !vld_q[TOTAL_LAT-1] || euler_out.ready;
	assign quat_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], quat_in.valid};
		end
	end

	// Stage 1: the component products, all but w*w.
	logic signed [PROD_W-1:0] wx_s1, yz_s1, wz_s1, xy_s1, wy_s1, zx_s1, xx_s1, yy_s1, zz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= quat_in.quat_w * quat_in.quat_x;
			yz_s1 <= quat_in.quat_y * quat_in.quat_z;
			wz_s1 <= quat_in.quat_w * quat_in.quat_z;
			xy_s1 <= quat_in.quat_x * quat_in.quat_y;
			wy_s1 <= quat_in.quat_w * quat_in.quat_y;
			zx_s1 <= quat_in.quat_z * quat_in.quat_x;
			xx_s1 <= quat_in.quat_x * quat_in.quat_x;
			yy_s1 <= quat_in.quat_y * quat_in.quat_y;
			zz_s1 <= quat_in.quat_z * quat_in.quat_z;
		end
	end

	// Stage 2: arctangent operands and the saturated arcsine argument.
	logic signed [SUM_W-1:0] rn_s2, rd_s2, yn_s2, yd_s2, pa_full;
	logic signed [PA_W-1:0]  pa_s2;
	logic                    clamp_s2;

	assign pa_full = (SUM_W'(wy_s1) - SUM_W'(zx_s1)) <<< 1;

	always_ff @(posedge clk) begin
		if (en) begin
			rn_s2 <= (SUM_W'(wx_s1) + SUM_W'(yz_s1)) <<< 1;
			rd_s2 <= ONE_Q28 - ((SUM_W'(xx_s1) + SUM_W'(yy_s1)) <<< 1);
			yn_s2 <= (SUM_W'(wz_s1) + SUM_W'(xy_s1)) <<< 1;
			yd_s2 <= ONE_Q28 - ((SUM_W'(yy_s1) + SUM_W'(zz_s1)) <<< 1);
			if (pa_full > ONE_Q28) begin
				pa_s2    <= PA_W'(ONE_Q28);
				clamp_s2 <= 1'b1;
			end else if (pa_full < -ONE_Q28) begin
				pa_s2    <= PA_W'(-ONE_Q28);
				clamp_s2 <= 1'b1;
			end else begin
				pa_s2    <= PA_W'(pa_full);
				clamp_s2 <= 1'b0;
			end
		end
	end

	// Stage 3: radicand one minus the squared argument, in Q.56.
	logic signed [SQ_W-1:0]  pa_sq;
	logic [REM_W-1:0]        rad_s3;
	logic signed [SUM_W-1:0] rn_s3, rd_s3, yn_s3, yd_s3;
	logic signed [PA_W-1:0]  pa_s3;
	logic                    clamp_s3;

	assign pa_sq = pa_s2 * pa_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3   <= (REM_W'(1) << 56) - REM_W'(pa_sq);
			rn_s3    <= rn_s2;
			rd_s3    <= rd_s2;
			yn_s3    <= yn_s2;
			yd_s3    <= yd_s2;
			pa_s3    <= pa_s2;
			clamp_s3 <= clamp_s2;
		end
	end

	// Square root of the radicand, with the other operands delayed to match.
	logic [ROOT_BITS-1:0] root;

	qte_isqrt u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand (rad_s3),
		.root     (root)
	);

	logic signed [SUM_W-1:0] rn_dq [0:SQRT_LAT-1];
	logic signed [SUM_W-1:0] rd_dq [0:SQRT_LAT-1];
	logic signed [SUM_W-1:0] yn_dq [0:SQRT_LAT-1];
	logic signed [SUM_W-1:0] yd_dq [0:SQRT_LAT-1];
	logic signed [PA_W-1:0]  pa_dq [0:SQRT_LAT-1];
	logic [SQRT_LAT+CORDIC_LAT-1:0] clamp_dq;

	always_ff @(posedge clk) begin
		if (en) begin
			rn_dq[0] <= rn_s3;
			rd_dq[0] <= rd_s3;
			yn_dq[0] <= yn_s3;
			yd_dq[0] <= yd_s3;
			pa_dq[0] <= pa_s3;
			for (int k = 1; k < SQRT_LAT; k++) begin
				rn_dq[k] <= rn_dq[k-1];
				rd_dq[k] <= rd_dq[k-1];
				yn_dq[k] <= yn_dq[k-1];
				yd_dq[k] <= yd_dq[k-1];
				pa_dq[k] <= pa_dq[k-1];
			end
			clamp_dq <= {clamp_dq[SQRT_LAT+CORDIC_LAT-2:0], clamp_s3};
		end
	end

	// Three arctangent pipelines in lockstep.
	logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;

	qte_cordic u_roll (
		.clk   (clk),
		.en    (en),
		.num   (CW'(rn_dq[SQRT_LAT-1])),
		.den   (CW'(rd_dq[SQRT_LAT-1])),
		.angle (roll_z)
	);

	qte_cordic u_pitch (
		.clk   (clk),
		.en    (en),
		.num   (CW'(pa_dq[SQRT_LAT-1])),
		.den   (CW'(signed'({1'b0, root}))),
		.angle (pitch_z)
	);

	qte_cordic u_yaw (
		.clk   (clk),
		.en    (en),
		.num   (CW'(yn_dq[SQRT_LAT-1])),
		.den   (CW'(yd_dq[SQRT_LAT-1])),
		.angle (yaw_z)
	);

	// Output register: round to Q3.12 and saturate.
	logic signed [RW-1:0] roll_r, pitch_r, yaw_r;

	assign roll_r  = round_sat(roll_z, LIM_PI);
	assign pitch_r = round_sat(pitch_z, LIM_HALF_PI);
	assign yaw_r   = round_sat(yaw_z, LIM_PI);

	always_ff @(posedge clk) begin
		if (en) begin
			euler_out.roll_angle    <= ROLL_W'(roll_r);
			euler_out.pitch_angle   <= PITCH_W'(pitch_r);
			euler_out.yaw_angle     <= ROLL_W'(yaw_r);
			euler_out.pitch_clamped <= clamp_dq[SQRT_LAT+CORDIC_LAT-1];
		end
	end

	assign euler_out.valid = vld_q[TOTAL_LAT-1];

	// Checks on pipeline control and result ranges.
	a_ready_tracks_drain: assert property (@(posedge clk) disable iff (!arst_n)
		quat_in.ready == (!euler_out.valid || euler_out.ready))
		else $error("input ready does not follow output drain");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(euler_out.valid && !euler_out.ready) |=> $stable(vld_q))
		else $error("pipeline moved while output stalled");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		euler_out.valid |-> (euler_out.roll_angle <= ROLL_W'(LIM_PI)
			&& euler_out.roll_angle >= -ROLL_W'(LIM_PI)))
		else $error("roll out of range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		euler_out.valid |-> (euler_out.pitch_angle <= PITCH_W'(LIM_HALF_PI)
			&& euler_out.pitch_angle >= -PITCH_W'(LIM_HALF_PI)))
		else $error("pitch out of range");

endmodule

// ----- test/tb_quaternion_to_euler_angles.sv -----
// Self-checking testbench for quaternion_to_euler_angles: random and directed quaternions
// go through the valid/ready channels, and each Euler result is checked against an
// in-bench fixed-point CORDIC predictor. Depends on qte_pkg, qte_if and the block's RTL.
`timescale 1ns / 1ps

module tb_quaternion_to_euler_angles;
	import qte_pkg::*;

	typedef struct {
		logic signed [QW-1:0] w, x, y, z;
	} quat_t;

	typedef struct {
		logic signed [ROLL_W-1:0]  roll;
		logic signed [PITCH_W-1:0] pitch;
		logic signed [ROLL_W-1:0]  yaw;
		logic                      clamped;
	} euler_t;

	localparam longint Q28 = 64'sd1 << 28;
	localparam longint PI20 = 3294199;
	localparam int TIMEOUT_CYCLES = 20000;

	logic clk;
	logic arst_n;
	qte_quat_if  quat_ch();
	qte_euler_if euler_ch();

	quaternion_to_euler_angles uut (
		.clk(clk),
		.arst_n(arst_n),
		.quat_in(quat_ch.sink),
		.euler_out(euler_ch.source)
	);

	quat_t  pending_quats[$];
	euler_t expected_angles[$];
	int     errors = 0;
	int     idle_cycles = 0;
	bit     stim_done = 0;
	bit     hold_for_drain = 0;
	int     send_gap = 0;
	int     recv_gap = 0;

	// Arctangent table in Q.20 radians.
	function automatic longint atan_step(input int i);
		longint tbl[20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
			4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
		return tbl[i];
	endfunction

	// Vectoring CORDIC, giving atan2(n, d) in Q.20 radians.
	function automatic longint vector_angle(input longint n, input longint d);
		longint ang;
		longint dn, dd;
		ang = 0;
		if (n == 0 && d == 0) begin
			return 0;
		end
		if (d < 0) begin
			ang = (n >= 0) ? PI20 : -PI20;
			d = -d;
			n = -n;
		end
		for (int i = 0; i < 20; i++) begin
			dn = n >>> i;
			dd = d >>> i;
			if (n >= 0) begin
				d += dn;
				n -= dd;
				ang += atan_step(i);
			end else begin
				d -= dn;
				n += dd;
				ang -= atan_step(i);
			end
		end
		return ang;
	endfunction

	// Rounds a Q.20 angle to Q3.12 and saturates it.
	function automatic longint round_angle(input longint a, input longint lim);
		longint r;
		r = (a + 128) >>> 8;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic longint floor_root(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	// Predicts the Euler angles of one quaternion.
	function automatic euler_t euler_of(input quat_t q);
		longint w, x, y, z, pa, pc;
		euler_t e;
		w = q.w;
		x = q.x;
		y = q.y;
		z = q.z;
		pa = 2 * (w * y - z * x);
		e.clamped = 0;
		if (pa > Q28) begin
			pa = Q28;
			e.clamped = 1;
		end
		if (pa < -Q28) begin
			pa = -Q28;
			e.clamped = 1;
		end
		pc = floor_root((64'd1 << 56) - longint'(pa * pa));
		e.roll = ROLL_W'(round_angle(vector_angle(2 * (w * x + y * z),
			Q28 - 2 * (x * x + y * y)), 12868));
		e.pitch = PITCH_W'(round_angle(vector_angle(pa, pc), 6434));
		e.yaw = ROLL_W'(round_angle(vector_angle(2 * (w * z + x * y),
			Q28 - 2 * (y * y + z * z)), 12868));
		return e;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic signed [QW-1:0] rand_comp();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return QW'($urandom);
		if (r == 1) return ($urandom_range(0, 1) == 1) ? 16'sd16384 : -16'sd16384;
		return QW'($urandom_range(0, 32768) - 16384);
	endfunction

	// Random unit quaternion with random content; a share stays raw or unnormalized.
	function automatic quat_t rand_quat();
		quat_t q;
		real a, b, c, d, n;
		if ($urandom_range(0, 9) < 2) begin
			q.w = rand_comp();
			q.x = rand_comp();
			q.y = rand_comp();
			q.z = rand_comp();
			return q;
		end
		a = real'(int'($urandom_range(0, 2000)) - 1000);
		b = real'(int'($urandom_range(0, 2000)) - 1000);
		c = real'(int'($urandom_range(0, 2000)) - 1000);
		d = real'(int'($urandom_range(0, 2000)) - 1000);
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n == 0.0) n = 1.0;
		q.w = QW'($rtoi(a / n * 16384.0));
		q.x = QW'($rtoi(b / n * 16384.0));
		q.y = QW'($rtoi(c / n * 16384.0));
		q.z = QW'($rtoi(d / n * 16384.0));
		return q;
	endfunction

	function automatic quat_t mk(input int w, input int x, input int y, input int z);
		quat_t q;
		q.w = QW'(w);
		q.x = QW'(x);
		q.y = QW'(y);
		q.z = QW'(z);
		return q;
	endfunction

	// Clock.
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Reset and stimulus.
	initial begin
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		// Directed: identity, extremes, zero, gimbal lock, clamping, raw bit patterns.
		pending_quats.push_back(mk(16384, 0, 0, 0));
		pending_quats.push_back(mk(0, 0, 0, 0));
		pending_quats.push_back(mk(-16384, 0, 0, 0));
		pending_quats.push_back(mk(0, 16384, 0, 0));
		pending_quats.push_back(mk(0, 0, 16384, 0));
		pending_quats.push_back(mk(0, 0, 0, 16384));
		pending_quats.push_back(mk(11585, 0, 11585, 0));
		pending_quats.push_back(mk(11585, 0, -11585, 0));
		pending_quats.push_back(mk(16384, 0, 16384, 0));
		pending_quats.push_back(mk(16384, 0, -16384, 0));
		pending_quats.push_back(mk(16384, 16384, 16384, 16384));
		pending_quats.push_back(mk(-16384, -16384, -16384, -16384));
		pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
		pending_quats.push_back(mk(32767, 32767, 32767, 32767));
		pending_quats.push_back(mk(32767, -32768, 32767, -32768));
		pending_quats.push_back(mk(0, 0, 11585, 11585));
		pending_quats.push_back(mk(0, 11585, 0, -11585));
		pending_quats.push_back(mk(8192, 8192, 8192, 8192));
		pending_quats.push_back(mk(-1, -1, -1, -1));
		pending_quats.push_back(mk(1, 0, 0, 0));
		for (int i = 0; i < 1500; i++) begin
			pending_quats.push_back(rand_quat());
			// Let the pipeline drain completely once, midway.
			if (i == 700) begin
				wait (pending_quats.size() == 0);
				hold_for_drain = 1;
				// The last item is on the channel by the next edge.
				@(posedge clk);
				wait (!quat_ch.valid && expected_angles.size() == 0);
				hold_for_drain = 0;
			end
		end
		wait (pending_quats.size() == 0);
		@(posedge clk);
		wait (!quat_ch.valid);
		stim_done = 1;
	end

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_ch.valid <= 0;
			quat_ch.quat_w <= '0;
			quat_ch.quat_x <= '0;
			quat_ch.quat_y <= '0;
			quat_ch.quat_z <= '0;
			send_gap <= 0;
		end else begin
			if (quat_ch.valid && quat_ch.ready) begin
				expected_angles.push_back(euler_of('{quat_ch.quat_w, quat_ch.quat_x,
					quat_ch.quat_y, quat_ch.quat_z}));
			end
			if (!quat_ch.valid || quat_ch.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					quat_ch.valid <= 0;
				end else if (pending_quats.size() > 0 && !hold_for_drain) begin
					quat_t q;
					q = pending_quats.pop_front();
					quat_ch.valid <= 1;
					quat_ch.quat_w <= q.w;
					quat_ch.quat_x <= q.x;
					quat_ch.quat_y <= q.y;
					quat_ch.quat_z <= q.z;
					send_gap <= pick_gap();
				end else begin
					quat_ch.valid <= 0;
				end
			end
		end
	end

	// Monitor, output stalls and watchdog.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			euler_ch.ready <= 0;
			recv_gap <= 0;
		end else begin
			if (euler_ch.valid && euler_ch.ready) begin
				if (expected_angles.size() == 0) begin
					$display("%0t: result with none expected: roll %0d pitch %0d yaw %0d",
						$time, euler_ch.roll_angle, euler_ch.pitch_angle, euler_ch.yaw_angle);
					errors++;
				end else begin
					euler_t e;
					e = expected_angles.pop_front();
					if (e.roll !== euler_ch.roll_angle) begin
						$display("%0t: roll expected %0d actual %0d", $time, e.roll,
							euler_ch.roll_angle);
						errors++;
					end
					if (e.pitch !== euler_ch.pitch_angle) begin
						$display("%0t: pitch expected %0d actual %0d", $time, e.pitch,
							euler_ch.pitch_angle);
						errors++;
					end
					if (e.yaw !== euler_ch.yaw_angle) begin
						$display("%0t: yaw expected %0d actual %0d", $time, e.yaw,
							euler_ch.yaw_angle);
						errors++;
					end
					if (e.clamped !== euler_ch.pitch_clamped) begin
						$display("%0t: pitch_clamped expected %0b actual %0b", $time,
							e.clamped, euler_ch.pitch_clamped);
						errors++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				euler_ch.ready <= 0;
			end else begin
				euler_ch.ready <= 1;
				if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
			end
			if ((quat_ch.valid && quat_ch.ready) || (euler_ch.valid && euler_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// End of run.
	initial begin
		wait (stim_done && expected_angles.size() == 0);
		repeat (TOTAL_LAT + 10) @(posedge clk);
		if (errors == 0 && expected_angles.size() == 0)
			$display("tb_quaternion_to_euler_angles OK");
		else
			$display("tb_quaternion_to_euler_angles NOT OK");
		$finish;
	end

	initial begin
		wait (idle_cycles >= TIMEOUT_CYCLES);
		$display("tb_quaternion_to_euler_angles NOT OK");
		$finish;
	end

endmodule
